### hdl/pip_pkg.sv
`default_nettype none

package pip_pkg;

  // Field widths fixed by the interface.
  localparam int COORD_W  = 24;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int PROD_W   = 2 * DIFF_W;
  localparam int ORIENT_W = PROD_W + 1;
  localparam int COUNT_W  = 5;
  localparam int INDEX_W  = 4;

  // A polygon needs at least this many vertices to enclose anything.
  localparam logic [COUNT_W-1:0] MIN_POLY_VERTICES = 5'd3;

  // Request type codes.
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TEST = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DIFF,
    ST_MUL_A,
    ST_MUL_B,
    ST_SIDE,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

### hdl/point_in_convex_polygon.sv
// Point-in-convex-polygon test by edge orientation.
// Input channel (in_valid/in_ready) carries two kinds of transaction. A load
// (req_type low) writes one vertex into slot vertex_index and gives no result;
// slots at or above MAX_VERTICES are ignored. A test (req_type high) checks the
// point coord_x/coord_y against the stored polygon and gives one transaction
// on the output channel (out_valid/out_ready) with inside_res set when every
// edge, including the closing edge back to vertex 0, sees the point on the
// same side. Coordinates are signed with 12 fraction bits; products are exact.
// The user must write vertex_count through cfg_wr_en/cfg_wr_data only while
// the block is idle; the block does not enforce this. Below 3 vertices a test
// answers outside in the cycle after acceptance. A load leaves the block ready.
// A test with n vertices in use (n limited to MAX_VERTICES) reads one vertex
// per edge from the vertex RAM and makes two passes per edge
// through the single shared 25x25 multiplier and one 51-bit subtract.
// The block handles one transaction at a time and holds in_ready low until the
// result has been taken, so a stalled receiver simply holds the block.
// Reset clears vertex_count and the sequencer; vertex contents are undefined
// until loaded.
`default_nettype none

module point_in_convex_polygon #(
  parameter int MAX_VERTICES = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_wr_en,
  input  wire logic [pip_pkg::COUNT_W-1:0]     cfg_wr_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            req_type,
  input  wire logic [pip_pkg::INDEX_W-1:0]     vertex_index,
  input  wire logic signed [pip_pkg::COORD_W-1:0] coord_x,
  input  wire logic signed [pip_pkg::COORD_W-1:0] coord_y,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 inside_res
);

  localparam int AW       = $clog2(MAX_VERTICES);
  localparam int RAM_W    = 2 * pip_pkg::COORD_W;
  localparam int LAST_IDX = MAX_VERTICES - 1;

  pip_pkg::state_t state, state_next;

  logic [pip_pkg::COUNT_W-1:0] vertex_count;

  logic signed [pip_pkg::COORD_W-1:0] px, py;
  logic [AW-1:0] idx, last_idx;
  logic          closing;

  logic signed [pip_pkg::DIFF_W-1:0] ax, ay, bx, by, fx, fy;
  logic signed [pip_pkg::PROD_W-1:0] prod_a, prod_b;
  logic signed [pip_pkg::DIFF_W-1:0] mul_op1, mul_op2;
  logic signed [pip_pkg::PROD_W-1:0] mul_out;
  logic signed [pip_pkg::ORIENT_W-1:0] orient;
  logic          is_left;
  logic          saw_left, saw_right;
  logic          left_now, right_now;
  logic          res;

  logic          in_xfer, out_xfer;
  logic          is_test, too_few, slot_ok;
  logic          ram_wr_en, ram_rd_en;
  logic [AW-1:0] ram_wr_addr;
  logic [RAM_W-1:0] ram_wr_data, ram_rd_data;
  logic signed [pip_pkg::COORD_W-1:0] rd_x, rd_y;
  logic signed [pip_pkg::DIFF_W-1:0] diff_x, diff_y;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;
  assign is_test  = (req_type == pip_pkg::REQ_TEST);
  assign too_few  = (vertex_count < pip_pkg::MIN_POLY_VERTICES);
  assign slot_ok  = (32'(vertex_index) < MAX_VERTICES);

  // Vertex RAM: x in the upper half, y in the lower half of each word.
  assign ram_wr_en   = in_xfer && !is_test && slot_ok;
  assign ram_wr_addr = AW'(vertex_index);
  assign ram_wr_data = {coord_x, coord_y};

  pip_ram #(
    .WIDTH(RAM_W),
    .DEPTH(MAX_VERTICES)
  ) u_vertex_ram (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_en  (ram_rd_en),
    .rd_addr(idx),
    .rd_data(ram_rd_data)
  );

  // Vertex position relative to the query point.
  assign rd_x   = ram_rd_data[RAM_W-1:pip_pkg::COORD_W];
  assign rd_y   = ram_rd_data[pip_pkg::COORD_W-1:0];
  assign diff_x = {rd_x[pip_pkg::COORD_W-1], rd_x} - {px[pip_pkg::COORD_W-1], px};
  assign diff_y = {rd_y[pip_pkg::COORD_W-1], rd_y} - {py[pip_pkg::COORD_W-1], py};

  // Shared multiplier: a.x*b.y in the first pass, a.y*b.x in the second.
  assign mul_op1 = (state == pip_pkg::ST_MUL_A) ? ax : ay;
  assign mul_op2 = (state == pip_pkg::ST_MUL_A) ? by : bx;
  assign mul_out = mul_op1 * mul_op2;

  // Orientation of the edge; strictly positive means left.
  assign orient    = {prod_a[pip_pkg::PROD_W-1], prod_a} - {prod_b[pip_pkg::PROD_W-1], prod_b};
  assign is_left   = !orient[pip_pkg::ORIENT_W-1] && (orient != '0);
  assign left_now  = saw_left || is_left;
  assign right_now = saw_right || !is_left;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
    end else if (cfg_wr_en) begin
      vertex_count <= cfg_wr_data;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      pip_pkg::ST_IDLE: begin
        if (in_xfer && is_test) begin
          state_next = too_few ? pip_pkg::ST_DONE : pip_pkg::ST_READ;
        end
      end
      pip_pkg::ST_READ:  state_next = pip_pkg::ST_DIFF;
      pip_pkg::ST_DIFF: begin
        state_next = (idx == '0) ? pip_pkg::ST_READ : pip_pkg::ST_MUL_A;
      end
      pip_pkg::ST_MUL_A: state_next = pip_pkg::ST_MUL_B;
      pip_pkg::ST_MUL_B: state_next = pip_pkg::ST_SIDE;
      pip_pkg::ST_SIDE: begin
        if (closing) begin
          state_next = pip_pkg::ST_DONE;
        end else if (idx == last_idx) begin
          state_next = pip_pkg::ST_MUL_A;
        end else begin
          state_next = pip_pkg::ST_READ;
        end
      end
      pip_pkg::ST_DONE: begin
        if (out_xfer) begin
          state_next = pip_pkg::ST_IDLE;
        end
      end
      default: state_next = pip_pkg::ST_IDLE;
    endcase
  end

  // Outputs decoded from the state.
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    ram_rd_en = 1'b0;
    case (state)
      pip_pkg::ST_IDLE: in_ready  = 1'b1;
      pip_pkg::ST_READ: ram_rd_en = 1'b1;
      pip_pkg::ST_DONE: out_valid = 1'b1;
      default: begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        ram_rd_en = 1'b0;
      end
    endcase
  end

  assign inside_res = res;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pip_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers, steered by the sequencer.
  always_ff @(posedge clk) begin
    case (state)
      pip_pkg::ST_IDLE: begin
        if (in_xfer && is_test) begin
          px        <= coord_x;
          py        <= coord_y;
          idx       <= '0;
          closing   <= 1'b0;
          saw_left  <= 1'b0;
          saw_right <= 1'b0;
          res       <= 1'b0;
          if (32'(vertex_count) > MAX_VERTICES) begin
            last_idx <= AW'(LAST_IDX);
          end else begin
            last_idx <= AW'(vertex_count - 5'd1);
          end
        end
      end
      pip_pkg::ST_DIFF: begin
        if (idx == '0) begin
          // First vertex: keep it for the closing edge.
          fx  <= diff_x;
          fy  <= diff_y;
          ax  <= diff_x;
          ay  <= diff_y;
          idx <= idx + AW'(1);
        end else begin
          bx <= diff_x;
          by <= diff_y;
        end
      end
      pip_pkg::ST_MUL_A: prod_a <= mul_out;
      pip_pkg::ST_MUL_B: prod_b <= mul_out;
      pip_pkg::ST_SIDE: begin
        saw_left  <= left_now;
        saw_right <= right_now;
        ax        <= bx;
        ay        <= by;
        if (closing) begin
          res <= !(left_now && right_now);
        end else if (idx == last_idx) begin
          // Last vertex done; the closing edge goes back to vertex 0.
          closing <= 1'b1;
          bx      <= fx;
          by      <= fy;
        end else begin
          idx <= idx + AW'(1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

### hdl/pip_ram.sv
`default_nettype none

module pip_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port and a registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire
